// File: sv/ssi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared widths, types and constants of the segment intersection core.
// ----------------------------------------------------------------------------
package ssi_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int RATIO_BITS = 24;
    localparam int DW         = COORD_BITS + 1;
    localparam int PW         = 2 * DW;
    localparam int SW         = PW + 1;
    localparam int MW         = SW;
    localparam int RW         = MW + RATIO_BITS;
    localparam int OVF_SHIFT  = RATIO_BITS - FRAC_BITS;
    localparam int QDEPTH     = 4;
    localparam int QAW        = 2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] ax0;
        logic signed [COORD_BITS-1:0] ay0;
        logic signed [COORD_BITS-1:0] ax1;
        logic signed [COORD_BITS-1:0] ay1;
        logic signed [COORD_BITS-1:0] bx0;
        logic signed [COORD_BITS-1:0] by0;
        logic signed [COORD_BITS-1:0] bx1;
        logic signed [COORD_BITS-1:0] by1;
    } t_seg;

    typedef struct packed {
        logic                         parallel;
        logic                         hit;
        logic                         neg_a;
        logic                         neg_b;
        logic                         ovf_a;
        logic                         ovf_b;
        logic [MW-1:0]                mag_na;
        logic [MW-1:0]                mag_nb;
        logic [MW-1:0]                mag_den;
        logic                         numb_zero;
        logic                         neg_x;
        logic                         neg_y;
        logic [DW-1:0]                mag_dx;
        logic [DW-1:0]                mag_dy;
        logic signed [COORD_BITS-1:0] base_x;
        logic signed [COORD_BITS-1:0] base_y;
    } t_cls;

endpackage

// File: sv/ssi_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module ssi_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ssi_pkg::t_cls i_data,
    output logic          o_full,
    input  logic          i_pop,
    output ssi_pkg::t_cls o_data,
    output logic          o_empty
);

    ssi_pkg::t_cls                r_mem [0:ssi_pkg::QDEPTH-1];
    logic [ssi_pkg::QAW-1:0]      r_wp;
    logic [ssi_pkg::QAW-1:0]      r_rp;
    logic [ssi_pkg::QAW:0]        r_cnt;
    logic                         wr;
    logic                         rd;

    assign o_full  = (r_cnt == (ssi_pkg::QAW+1)'(ssi_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 1'b1;
            if (rd) r_rp <= r_rp + 1'b1;
            if (wr && !rd) r_cnt <= r_cnt + 1'b1;
            else if (rd && !wr) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_data;
    end

endmodule

// File: sv/ssi_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_front
// Accept segment pairs, form cross products and classify each pair.
// ----------------------------------------------------------------------------
module ssi_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ssi_pkg::t_seg i_seg,
    output logic          o_full,
    input  logic          i_q_full,
    output logic          o_q_push,
    output ssi_pkg::t_cls o_cls
);

    localparam int DW = ssi_pkg::DW;
    localparam int PW = ssi_pkg::PW;
    localparam int SW = ssi_pkg::SW;
    localparam int MW = ssi_pkg::MW;
    localparam int OS = ssi_pkg::OVF_SHIFT;
    localparam int CB = ssi_pkg::COORD_BITS;

    function automatic logic signed [DW-1:0] sub(input logic signed [CB-1:0] a,
                                                 input logic signed [CB-1:0] b);
        sub = DW'(a) - DW'(b);
    endfunction

    function automatic logic [MW-1:0] mag(input logic signed [SW-1:0] v);
        mag = v[SW-1] ? MW'(-v) : MW'(v);
    endfunction

    logic                   en;
    logic                   r_v0, r_v1, r_v2, r_v3;
    ssi_pkg::t_seg          r_seg;
    logic signed [PW-1:0]   r_p1, r_p2, r_p3, r_p4, r_p5, r_p6;
    logic signed [DW-1:0]   r1_dx, r1_dy, r2_dx, r2_dy;
    logic signed [CB-1:0]   r1_bx, r1_by, r2_bx, r2_by;
    logic signed [SW-1:0]   r_den, r_na, r_nb;
    ssi_pkg::t_cls          r_cls;
    ssi_pkg::t_cls          n_cls;
    logic signed [DW-1:0]   dax, day, dbx, dby, wx, wy;
    logic                   in_a, in_b;

    assign en       = !r_v3 || !i_q_full;
    assign o_full   = !en;
    assign o_q_push = r_v3 && !i_q_full;
    assign o_cls    = r_cls;

    always_comb begin
        dax = sub(r_seg.ax1, r_seg.ax0);
        day = sub(r_seg.ay1, r_seg.ay0);
        dbx = sub(r_seg.bx1, r_seg.bx0);
        dby = sub(r_seg.by1, r_seg.by0);
        wx  = sub(r_seg.ax0, r_seg.bx0);
        wy  = sub(r_seg.ay0, r_seg.by0);
    end

    always_comb begin
        if (r_den[SW-1]) begin
            in_a = (r_na <= 0) && (r_na >= r_den);
            in_b = (r_nb <= 0) && (r_nb >= r_den);
        end else begin
            in_a = (r_na >= 0) && (r_na <= r_den);
            in_b = (r_nb >= 0) && (r_nb <= r_den);
        end
        n_cls.parallel  = (r_den == '0);
        n_cls.hit       = !n_cls.parallel && in_a && in_b;
        n_cls.neg_a     = r_na[SW-1] ^ r_den[SW-1];
        n_cls.neg_b     = r_nb[SW-1] ^ r_den[SW-1];
        n_cls.mag_na    = mag(r_na);
        n_cls.mag_nb    = mag(r_nb);
        n_cls.mag_den   = mag(r_den);
        n_cls.ovf_a     = {{OS{1'b0}}, n_cls.mag_na} >= {n_cls.mag_den, {OS{1'b0}}};
        n_cls.ovf_b     = {{OS{1'b0}}, n_cls.mag_nb} >= {n_cls.mag_den, {OS{1'b0}}};
        n_cls.numb_zero = (r_nb == '0);
        n_cls.neg_x     = r2_dx[DW-1] ^ n_cls.neg_b;
        n_cls.neg_y     = r2_dy[DW-1] ^ n_cls.neg_b;
        n_cls.mag_dx    = r2_dx[DW-1] ? DW'(-r2_dx) : DW'(r2_dx);
        n_cls.mag_dy    = r2_dy[DW-1] ? DW'(-r2_dy) : DW'(r2_dy);
        n_cls.base_x    = r2_bx;
        n_cls.base_y    = r2_by;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_push;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_seg <= i_seg;
            r_p1  <= dby * dax;
            r_p2  <= dbx * day;
            r_p3  <= dbx * wy;
            r_p4  <= dby * wx;
            r_p5  <= dax * wy;
            r_p6  <= day * wx;
            r1_dx <= dbx;
            r1_dy <= dby;
            r1_bx <= r_seg.bx0;
            r1_by <= r_seg.by0;
            r_den <= SW'(r_p1) - SW'(r_p2);
            r_na  <= SW'(r_p3) - SW'(r_p4);
            r_nb  <= SW'(r_p5) - SW'(r_p6);
            r2_dx <= r1_dx;
            r2_dy <= r1_dy;
            r2_bx <= r1_bx;
            r2_by <= r1_by;
            r_cls <= n_cls;
        end
    end

endmodule

// File: sv/ssi_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_back
// Pipelined ratio dividers and meeting-point scaling, one bit per stage.
// ----------------------------------------------------------------------------
module ssi_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_q_empty,
    input  ssi_pkg::t_cls                         i_cls,
    output logic                                  o_q_pop,
    output logic                                  o_empty,
    input  logic                                  i_pop,
    output logic                                  o_hit,
    output logic                                  o_parallel,
    output logic signed [ssi_pkg::RATIO_BITS-1:0] o_ratio_a,
    output logic signed [ssi_pkg::RATIO_BITS-1:0] o_ratio_b,
    output logic signed [ssi_pkg::COORD_BITS-1:0] o_meet_x,
    output logic signed [ssi_pkg::COORD_BITS-1:0] o_meet_y
);

    localparam int DW = ssi_pkg::DW;
    localparam int MW = ssi_pkg::MW;
    localparam int RW = ssi_pkg::RW;
    localparam int RB = ssi_pkg::RATIO_BITS;
    localparam int FB = ssi_pkg::FRAC_BITS;
    localparam int CB = ssi_pkg::COORD_BITS;
    localparam int NS = RB + 1;

    typedef struct packed {
        ssi_pkg::t_cls  cls;
        logic [RW-1:0]  ra_rem;
        logic [RB-1:0]  ra_q;
        logic [RW-1:0]  rb_rem;
        logic [RB-1:0]  rb_q;
        logic [DW-1:0]  ax;
        logic [DW-1:0]  ay;
        logic [MW-1:0]  mx_rem;
        logic [DW:0]    mx_q;
        logic [MW-1:0]  my_rem;
        logic [DW:0]    my_q;
    } t_bst;

    typedef struct packed {
        logic [MW-1:0] rem;
        logic [DW:0]   q;
    } t_mst;

    function automatic t_bst init(input ssi_pkg::t_cls c);
        t_bst s;
        s        = '0;
        s.cls    = c;
        s.ra_rem = RW'({c.mag_na, {FB{1'b0}}});
        s.rb_rem = RW'({c.mag_nb, {FB{1'b0}}});
        s.ax     = c.mag_dx;
        s.ay     = c.mag_dy;
        init     = s;
    endfunction

    function automatic logic [RW:0] div_bit(input logic [RW-1:0] rem,
                                            input logic [MW-1:0] d, input int k);
        logic [RW-1:0] trial;
        trial = RW'(d) << (RB - 1 - k);
        if (rem >= trial) div_bit = {1'b1, rem - trial};
        else div_bit = {1'b0, rem};
    endfunction

    function automatic t_mst meet_bit(input t_mst m, input logic a, input logic [MW-1:0] b,
                                      input logic [MW-1:0] d);
        logic [MW+1:0] r2;
        logic [MW+1:0] d1;
        logic [MW+1:0] d2;
        t_mst          o;
        r2 = {1'b0, m.rem, 1'b0} + (a ? {2'b00, b} : '0);
        d1 = {2'b00, d};
        d2 = {1'b0, d, 1'b0};
        if (r2 >= d2) begin
            o.rem = MW'(r2 - d2);
            o.q   = {m.q[DW-1:0], 1'b0} + (DW+1)'(2);
        end else if (r2 >= d1) begin
            o.rem = MW'(r2 - d1);
            o.q   = {m.q[DW-1:0], 1'b0} + (DW+1)'(1);
        end else begin
            o.rem = MW'(r2);
            o.q   = {m.q[DW-1:0], 1'b0};
        end
        meet_bit = o;
    endfunction

    function automatic t_bst step(input t_bst s, input int k);
        t_bst        o;
        logic [RW:0] da;
        logic [RW:0] db;
        t_mst        mx;
        t_mst        my;
        o        = s;
        da       = div_bit(s.ra_rem, s.cls.mag_den, k);
        db       = div_bit(s.rb_rem, s.cls.mag_den, k);
        o.ra_rem = da[RW-1:0];
        o.ra_q   = {s.ra_q[RB-2:0], da[RW]};
        o.rb_rem = db[RW-1:0];
        o.rb_q   = {s.rb_q[RB-2:0], db[RW]};
        if (k < DW) begin
            mx       = meet_bit('{rem: s.mx_rem, q: s.mx_q}, s.ax[DW-1], s.cls.mag_nb,
                                s.cls.mag_den);
            my       = meet_bit('{rem: s.my_rem, q: s.my_q}, s.ay[DW-1], s.cls.mag_nb,
                                s.cls.mag_den);
            o.mx_rem = mx.rem;
            o.mx_q   = mx.q;
            o.my_rem = my.rem;
            o.my_q   = my.q;
            o.ax     = {s.ax[DW-2:0], 1'b0};
            o.ay     = {s.ay[DW-2:0], 1'b0};
        end
        step = o;
    endfunction

    function automatic logic [RB-1:0] ratio(input logic [RB-1:0] q, input logic neg,
                                            input logic ovf);
        logic [RB-1:0] lim;
        logic [RB-1:0] qq;
        lim   = neg ? {1'b1, {(RB-1){1'b0}}} : {1'b0, {(RB-1){1'b1}}};
        qq    = (ovf || q > lim) ? lim : q;
        ratio = neg ? -qq : qq;
    endfunction

    function automatic logic [CB-1:0] meet(input logic signed [CB-1:0] base,
                                           input logic [MW-1:0] rem, input logic [DW:0] q,
                                           input logic [MW-1:0] d, input logic neg,
                                           input logic zero);
        logic [DW:0]   off;
        logic [DW+1:0] bx;
        off  = ({rem, 1'b0} >= {1'b0, d}) ? q + 1'b1 : q;
        bx   = (DW+2)'(base);
        if (zero) meet = base;
        else if (neg) meet = CB'(bx - {1'b0, off});
        else meet = CB'(bx + {1'b0, off});
    endfunction

    logic          en;
    logic [NS-1:0] r_bv;
    logic          r_ov;
    t_bst          r_bs [0:NS-1];
    t_bst          last;

    assign en      = !r_ov || i_pop;
    assign o_q_pop = en && !i_q_empty;
    assign o_empty = !r_ov;
    assign last    = r_bs[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_bv <= {r_bv[NS-2:0], !i_q_empty};
            r_ov <= r_bv[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bs[0] <= init(i_cls);
            for (int k = 0; k < NS - 1; k++) begin
                r_bs[k+1] <= step(r_bs[k], k);
            end
            o_hit      <= last.cls.hit;
            o_parallel <= last.cls.parallel;
            if (last.cls.parallel) begin
                o_ratio_a <= '0;
                o_ratio_b <= '0;
            end else begin
                o_ratio_a <= ratio(last.ra_q, last.cls.neg_a, last.cls.ovf_a);
                o_ratio_b <= ratio(last.rb_q, last.cls.neg_b, last.cls.ovf_b);
            end
            if (last.cls.hit) begin
                o_meet_x <= meet(last.cls.base_x, last.mx_rem, last.mx_q, last.cls.mag_den,
                                 last.cls.neg_x, last.cls.numb_zero);
                o_meet_y <= meet(last.cls.base_y, last.my_rem, last.my_q, last.cls.mag_den,
                                 last.cls.neg_y, last.cls.numb_zero);
            end else begin
                o_meet_x <= '0;
                o_meet_y <= '0;
            end
        end
    end

endmodule

// File: sv/segment_segment_intersection_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_segment_intersection_core
// Parametric intersection of two line segments with fixed-point ratios.
//
// Input side: a queue interface. Drive the eight endpoint coordinates and
// raise push; a transfer happens at a rising edge with push high and full
// low. Result side: while empty is low the oldest result is on the o_ ports;
// a transfer happens at a rising edge with pop high and empty low.
// Throughput is one pair per clock while results are taken. Between input
// transfer and result lie four front stages (input register, products,
// sums, classification), a queue write, 25 back stages of restoring
// division (a load stage, then one quotient bit per stage for the 24-bit
// ratios, the meeting-point scaling alongside), and the output register.
// When pop stays low the back pipeline holds, the queue fills, the front
// holds and full rises; nothing is dropped. Synchronous reset empties all
// stages and the queue; no result is pending after reset.
// ----------------------------------------------------------------------------
module segment_segment_intersection_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic signed [ssi_pkg::COORD_BITS-1:0] i_a_start_x,
    input  logic signed [ssi_pkg::COORD_BITS-1:0] i_a_start_y,
    input  logic signed [ssi_pkg::COORD_BITS-1:0] i_a_end_x,
    input  logic signed [ssi_pkg::COORD_BITS-1:0] i_a_end_y,
    input  logic signed [ssi_pkg::COORD_BITS-1:0] i_b_start_x,
    input  logic signed [ssi_pkg::COORD_BITS-1:0] i_b_start_y,
    input  logic signed [ssi_pkg::COORD_BITS-1:0] i_b_end_x,
    input  logic signed [ssi_pkg::COORD_BITS-1:0] i_b_end_y,
    output logic                                  empty,
    input  logic                                  pop,
    output logic                                  o_hit,
    output logic                                  o_parallel,
    output logic signed [ssi_pkg::RATIO_BITS-1:0] o_ratio_a,
    output logic signed [ssi_pkg::RATIO_BITS-1:0] o_ratio_b,
    output logic signed [ssi_pkg::COORD_BITS-1:0] o_meet_x,
    output logic signed [ssi_pkg::COORD_BITS-1:0] o_meet_y
);

    ssi_pkg::t_seg seg;
    ssi_pkg::t_cls f_cls;
    ssi_pkg::t_cls q_cls;
    logic          f_push;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;

    assign seg.ax0 = i_a_start_x;
    assign seg.ay0 = i_a_start_y;
    assign seg.ax1 = i_a_end_x;
    assign seg.ay1 = i_a_end_y;
    assign seg.bx0 = i_b_start_x;
    assign seg.by0 = i_b_start_y;
    assign seg.bx1 = i_b_end_x;
    assign seg.by1 = i_b_end_y;

    ssi_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_seg    (seg),
        .o_full   (full),
        .i_q_full (q_full),
        .o_q_push (f_push),
        .o_cls    (f_cls)
    );

    ssi_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_cls),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_cls),
        .o_empty (q_empty)
    );

    ssi_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_cls      (q_cls),
        .o_q_pop    (q_pop),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_hit      (o_hit),
        .o_parallel (o_parallel),
        .o_ratio_a  (o_ratio_a),
        .o_ratio_b  (o_ratio_b),
        .o_meet_x   (o_meet_x),
        .o_meet_y   (o_meet_y)
    );

endmodule

// File: test/segment_intersection_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_checker
// Watches both queue sides of the segment intersection core. Predicts each
// result from the accepted segment pair and compares it, field by field,
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module segment_intersection_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_push,
    input  logic                                  i_full,
    input  logic signed [ssi_pkg::COORD_BITS-1:0] i_ax0,
    input  logic signed [ssi_pkg::COORD_BITS-1:0] i_ay0,
    input  logic signed [ssi_pkg::COORD_BITS-1:0] i_ax1,
    input  logic signed [ssi_pkg::COORD_BITS-1:0] i_ay1,
    input  logic signed [ssi_pkg::COORD_BITS-1:0] i_bx0,
    input  logic signed [ssi_pkg::COORD_BITS-1:0] i_by0,
    input  logic signed [ssi_pkg::COORD_BITS-1:0] i_bx1,
    input  logic signed [ssi_pkg::COORD_BITS-1:0] i_by1,
    input  logic                                  i_empty,
    input  logic                                  i_pop,
    input  logic                                  i_hit,
    input  logic                                  i_parallel,
    input  logic signed [ssi_pkg::RATIO_BITS-1:0] i_ratio_a,
    input  logic signed [ssi_pkg::RATIO_BITS-1:0] i_ratio_b,
    input  logic signed [ssi_pkg::COORD_BITS-1:0] i_meet_x,
    input  logic signed [ssi_pkg::COORD_BITS-1:0] i_meet_y,
    output int                                    o_errors,
    output int                                    o_pending,
    output int                                    o_checked,
    output int                                    o_hits,
    output int                                    o_parallels
);

    localparam longint RATIO_POS_LIM = (64'sd1 <<< (ssi_pkg::RATIO_BITS - 1)) - 1;
    localparam longint RATIO_NEG_LIM = 64'sd1 <<< (ssi_pkg::RATIO_BITS - 1);

    typedef struct packed {
        logic                                  hit;
        logic                                  parallel;
        logic signed [ssi_pkg::RATIO_BITS-1:0] ratio_a;
        logic signed [ssi_pkg::RATIO_BITS-1:0] ratio_b;
        logic signed [ssi_pkg::COORD_BITS-1:0] meet_x;
        logic signed [ssi_pkg::COORD_BITS-1:0] meet_y;
    } t_meet;

    t_meet pending_results[$];

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic [ssi_pkg::RATIO_BITS-1:0] fixed_quotient(longint num,
                                                                      longint den);
        logic   neg;
        longint q;
        longint lim;
        neg = (num < 0) != (den < 0);
        lim = neg ? RATIO_NEG_LIM : RATIO_POS_LIM;
        q   = (magnitude(num) <<< ssi_pkg::FRAC_BITS) / magnitude(den);
        if (q > lim) q = lim;
        if (neg) q = -q;
        return q[ssi_pkg::RATIO_BITS-1:0];
    endfunction

    function automatic logic [ssi_pkg::COORD_BITS-1:0] meet_coord(longint base,
                                                                  longint delta,
                                                                  longint num,
                                                                  longint den);
        longint prod;
        longint d;
        longint off;
        logic   neg;
        if (num == 0) return base[ssi_pkg::COORD_BITS-1:0];
        d    = magnitude(den);
        prod = magnitude(delta) * magnitude(num);
        off  = prod / d;
        if (2 * (prod % d) >= d) off++;
        neg  = (delta < 0) != ((num < 0) != (den < 0));
        return neg ? ssi_pkg::COORD_BITS'(base - off) : ssi_pkg::COORD_BITS'(base + off);
    endfunction

    function automatic t_meet predict_intersection(ssi_pkg::t_seg s);
        t_meet  r;
        longint dax, day, dbx, dby, wx, wy, den, numa, numb;
        logic   in_a, in_b;
        r    = '0;
        dax  = longint'(s.ax1) - longint'(s.ax0);
        day  = longint'(s.ay1) - longint'(s.ay0);
        dbx  = longint'(s.bx1) - longint'(s.bx0);
        dby  = longint'(s.by1) - longint'(s.by0);
        wx   = longint'(s.ax0) - longint'(s.bx0);
        wy   = longint'(s.ay0) - longint'(s.by0);
        den  = dby * dax - dbx * day;
        if (den == 0) begin
            r.parallel = 1'b1;
            return r;
        end
        numa = dbx * wy - dby * wx;
        numb = dax * wy - day * wx;
        r.ratio_a = fixed_quotient(numa, den);
        r.ratio_b = fixed_quotient(numb, den);
        if (den > 0) begin
            in_a = numa >= 0 && numa <= den;
            in_b = numb >= 0 && numb <= den;
        end else begin
            in_a = numa <= 0 && numa >= den;
            in_b = numb <= 0 && numb >= den;
        end
        if (in_a && in_b) begin
            r.hit    = 1'b1;
            r.meet_x = meet_coord(s.bx0, dbx, numb, den);
            r.meet_y = meet_coord(s.by0, dby, numb, den);
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        ssi_pkg::t_seg s;
        t_meet         exp_r;
        t_meet         act_r;
        if (!i_rst_n) begin
            pending_results.delete();
            o_errors    <= 0;
            o_checked   <= 0;
            o_hits      <= 0;
            o_parallels <= 0;
        end else begin
            if (i_push && !i_full) begin
                s = '{i_ax0, i_ay0, i_ax1, i_ay1, i_bx0, i_by0, i_bx1, i_by1};
                pending_results.push_back(predict_intersection(s));
            end
            if (i_pop && !i_empty) begin
                act_r = '{i_hit, i_parallel, i_ratio_a, i_ratio_b, i_meet_x, i_meet_y};
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result transfer, actual %p", $time, act_r);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = pending_results.pop_front();
                    o_checked   <= o_checked + 1;
                    o_hits      <= o_hits + exp_r.hit;
                    o_parallels <= o_parallels + exp_r.parallel;
                    if (act_r !== exp_r) begin
                        $display("%0t: mismatch expected %p", $time, exp_r);
                        $display("%0t:          actual   %p", $time, act_r);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

    assign o_pending = pending_results.size();

endmodule

// File: test/tb_segment_segment_intersection_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_segment_intersection_core
// Drives directed and random segment pairs into the intersection core with
// random idling on both sides and one long result hold-off; the checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_segment_segment_intersection_core;

    localparam int NUM_RANDOM  = 1430;
    localparam int QUIET_FROM  = 1230;
    localparam int CYCLE_LIMIT = 300000;

    logic                                  i_clk;
    logic                                  i_rst_n;
    logic                                  push;
    logic                                  full;
    logic                                  empty;
    logic                                  pop;
    logic signed [ssi_pkg::COORD_BITS-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    logic                                  o_hit, o_parallel;
    logic signed [ssi_pkg::RATIO_BITS-1:0] o_ratio_a, o_ratio_b;
    logic signed [ssi_pkg::COORD_BITS-1:0] o_meet_x, o_meet_y;
    int                                    errors, pending, checked, hits, parallels;
    int                                    cycles;
    bit                                    quiet;
    bit                                    hold_req;

    segment_segment_intersection_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_a_start_x(ax0), .i_a_start_y(ay0), .i_a_end_x(ax1), .i_a_end_y(ay1),
        .i_b_start_x(bx0), .i_b_start_y(by0), .i_b_end_x(bx1), .i_b_end_y(by1),
        .empty(empty), .pop(pop), .o_hit(o_hit), .o_parallel(o_parallel),
        .o_ratio_a(o_ratio_a), .o_ratio_b(o_ratio_b),
        .o_meet_x(o_meet_x), .o_meet_y(o_meet_y)
    );

    segment_intersection_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_full(full),
        .i_ax0(ax0), .i_ay0(ay0), .i_ax1(ax1), .i_ay1(ay1),
        .i_bx0(bx0), .i_by0(by0), .i_bx1(bx1), .i_by1(by1),
        .i_empty(empty), .i_pop(pop), .i_hit(o_hit), .i_parallel(o_parallel),
        .i_ratio_a(o_ratio_a), .i_ratio_b(o_ratio_b),
        .i_meet_x(o_meet_x), .i_meet_y(o_meet_y),
        .o_errors(errors), .o_pending(pending), .o_checked(checked),
        .o_hits(hits), .o_parallels(parallels)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // result side: random stall bursts, one long hold-off on request
    initial begin
        int stall_left;
        pop        = 1'b0;
        stall_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                pop = 1'b0;
                repeat (300) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (quiet) begin
                pop = 1'b1;
            end else if (stall_left > 0) begin
                pop = 1'b0;
                stall_left--;
            end else if ($urandom_range(7) == 0) begin
                pop        = 1'b0;
                stall_left = $urandom_range(13);
            end else begin
                pop = 1'b1;
            end
        end
    end

    task automatic transfer_pair(input logic signed [ssi_pkg::COORD_BITS-1:0] p_ax0, p_ay0,
                                 p_ax1, p_ay1, p_bx0, p_by0, p_bx1, p_by1);
        @(negedge i_clk);
        if (!quiet && $urandom_range(9) == 0) begin
            push = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        {ax0, ay0, ax1, ay1} = {p_ax0, p_ay0, p_ax1, p_ay1};
        {bx0, by0, bx1, by1} = {p_bx0, p_by0, p_bx1, p_by1};
        push = 1'b1;
        do @(posedge i_clk); while (full);
    endtask

    function automatic logic signed [ssi_pkg::COORD_BITS-1:0] near(int centre, int span);
        return ssi_pkg::COORD_BITS'(centre + int'($urandom_range(2 * span)) - span);
    endfunction

    function automatic logic signed [ssi_pkg::COORD_BITS-1:0] any_coord();
        return ssi_pkg::COORD_BITS'($urandom);
    endfunction

    initial begin
        logic signed [ssi_pkg::COORD_BITS-1:0] c[8];
        int kind, span, cx, cy;
        quiet    = 1'b0;
        hold_req = 1'b0;
        push     = 1'b0;
        {ax0, ay0, ax1, ay1, bx0, by0, bx1, by1} = '0;
        i_rst_n  = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // degenerate, parallel, collinear
        transfer_pair(0, 0, 0, 0, 0, 0, 0, 0);
        transfer_pair(0, 0, 10, 0, 0, 5, 10, 5);
        transfer_pair(0, 0, 10, 10, 5, 5, 20, 20);
        // plain crossing, negative denominator, endpoint touches
        transfer_pair(0, 0, 10, 10, 0, 10, 10, 0);
        transfer_pair(0, 10, 10, 0, 0, 0, 10, 10);
        transfer_pair(0, 0, 10, 0, 0, 0, 0, 10);
        transfer_pair(0, 0, 10, 0, 10, 0, 10, 10);
        transfer_pair(0, 0, 10, 0, 5, 5, 5, 0);
        // miss on each side
        transfer_pair(0, 0, 10, 0, 20, -5, 20, 5);
        transfer_pair(0, 0, 10, 0, 5, 1, 5, 9);
        transfer_pair(0, 0, 10, 0, 5, -9, 5, -1);
        // rounding halves of the meeting point
        transfer_pair(0, 0, 1, 0, 0, -1, 1, 1);
        transfer_pair(0, 0, -1, 0, 0, -1, -1, 1);
        transfer_pair(0, 0, 2, 1, 0, 1, 3, 0);
        // coordinate extremes and saturation
        transfer_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
        transfer_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
        transfer_pair(-32768, 0, 32767, 1, 0, -32768, 1, 32767);
        transfer_pair(-32768, -32768, -32767, -32768, 32767, 32767, 32767, 32766);
        transfer_pair(32767, 32767, 32766, 32767, -32768, -32768, -32768, -32767);
        transfer_pair(0, 0, 1, 1, 32767, -32768, -32768, 32767);
        transfer_pair(-1, -1, -1, -1, -1, -1, -1, -1);

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == 150) hold_req = 1'b1;
            if (n == QUIET_FROM) quiet = 1'b1;
            kind = $urandom_range(19);
            if (kind < 11) begin
                // crossing candidates in a shared box
                span = ($urandom_range(3) == 0) ? 32767 : (1 << $urandom_range(1, 12));
                cx = (span == 32767) ? 0 : int'($urandom_range(40000)) - 20000;
                cy = (span == 32767) ? 0 : int'($urandom_range(40000)) - 20000;
                foreach (c[k]) c[k] = (k % 2 == 0) ? near(cx, span) : near(cy, span);
            end else if (kind < 16) begin
                foreach (c[k]) c[k] = any_coord();
            end else if (kind < 18) begin
                // parallel or collinear: second segment shifted copy of the first
                c[0] = near(0, 2000); c[1] = near(0, 2000);
                c[2] = near(0, 2000); c[3] = near(0, 2000);
                cx = $urandom_range(1) ? 0 : int'($urandom_range(200)) - 100;
                c[4] = ssi_pkg::COORD_BITS'(c[0] + cx);
                c[5] = ssi_pkg::COORD_BITS'(c[1] + cx);
                c[6] = ssi_pkg::COORD_BITS'(c[2] + cx);
                c[7] = ssi_pkg::COORD_BITS'(c[3] + cx);
            end else begin
                // shared endpoint
                foreach (c[k]) c[k] = any_coord();
                c[4] = c[2]; c[5] = c[3];
            end
            transfer_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
        end
        @(negedge i_clk);
        push = 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("checked %0d results: %0d hits, %0d parallel pairs",
                 checked, hits, parallels);
        $display("random mix of crossing boxes, full-range, parallel and shared endpoints");
        if (errors == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
